>>> rtl/rbcfp_pkg.sv
// Shared types and constants for the repeated-byte command and frame parser.
`default_nettype none

package rbcfp_pkg;

    // Width of the run and header counters, and the value at which they saturate
    localparam int unsigned COUNT_W   = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;

    // Command and frame marker bytes
    localparam logic [7:0] FRAME_OPEN_BYTE = 8'hFF;
    localparam logic [7:0] COARSE_BYTE     = 8'hD0;
    localparam logic [7:0] FINE_BYTE       = 8'hD1;

    // Mode command bytes, listed in mode code order (home first, recall last)
    localparam int unsigned NUM_MODES = 27;
    localparam logic [7:0] MODE_BYTES [NUM_MODES] = '{
        8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
        8'hE6, 8'hE7, 8'hE8, 8'hE9, 8'hEA, 8'hEB,
        8'hF8, 8'hF9, 8'hFA, 8'hE0, 8'hE1, 8'hFB, 8'hE2, 8'hE3,
        8'hFC, 8'hE4, 8'hE5, 8'hEC, 8'hED
    };

    // Checksum length register
    localparam int unsigned CSUM_LEN_W     = 3;
    localparam logic [CSUM_LEN_W-1:0] CSUM_LEN_RESET = 3'd3;
    localparam logic [CSUM_LEN_W-1:0] CSUM_LEN_MIN   = 3'd1;
    localparam logic [CSUM_LEN_W-1:0] CSUM_LEN_MAX   = 3'd4;

    // Frame index bytes taken from the start of the payload
    localparam logic [7:0] INDEX_BYTES = 8'd8;

    // Frame completion status
    typedef enum logic [1:0] {
        STATUS_ACCEPTED       = 2'd0,
        STATUS_INDEX_MISMATCH = 2'd1,
        STATUS_CSUM_MISMATCH  = 2'd2
    } frame_status_t;

    // Input transaction
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [62:0] expected_index;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic        mode_valid;
        logic [4:0]  mode_code;
        logic        fine_valid;
        logic        fine_value;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_pos;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [62:0] frame_index;
    } out_item_t;

    // Command decoder result
    typedef struct packed {
        logic       mode_valid;
        logic [4:0] mode_code;
        logic       fine_valid;
        logic       fine_value;
    } cmd_res_t;

    // Frame tracker result
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_pos;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [62:0] frame_index;
    } frame_res_t;

    // Mode lookup result
    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } mode_hit_t;

    // Look a byte up in the mode table
    function automatic mode_hit_t mode_lookup(input logic [7:0] b);
        mode_hit_t res;
        res = '0;
        for (int i = 0; i < NUM_MODES; i++)
        begin
            if (MODE_BYTES[i] == b)
            begin
                res.hit  = 1'b1;
                res.code = 5'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rbcfp_in_if.sv
// Input channel interface: valid/ready handshake carrying one received byte.
`default_nettype none

interface rbcfp_in_if;
    logic                valid;
    logic                ready;
    rbcfp_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/rbcfp_out_if.sv
// Result channel interface: valid/ready handshake carrying one parser result.
`default_nettype none

interface rbcfp_out_if;
    logic                 valid;
    logic                 ready;
    rbcfp_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/rbcfp_cmd_decode.sv
// Command run decoder: counts repeated bytes and decodes mode and fine/coarse commands.
`default_nettype none

module rbcfp_cmd_decode #(
    parameter int unsigned HEADER_REPEAT = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic [7:0]          rx_byte,
    output rbcfp_pkg::cmd_res_t      res
);

    logic [7:0]                     last_byte_reg, last_byte_next;
    logic [rbcfp_pkg::COUNT_W-1:0]  run_count_reg, run_count_next;
    logic [rbcfp_pkg::COUNT_W-1:0]  run;
    rbcfp_pkg::mode_hit_t           hit;
    logic                           run_fires;

    // Extend the run of identical bytes, or restart it
    always_comb
    begin
        if (rx_byte == last_byte_reg)
        begin
            run = (run_count_reg < rbcfp_pkg::COUNT_MAX) ? run_count_reg + 1'b1
                                                          : rbcfp_pkg::COUNT_MAX;
        end
        else
        begin
            run = {{(rbcfp_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end
    end

    assign hit       = rbcfp_pkg::mode_lookup(rx_byte);
    assign run_fires = (run == rbcfp_pkg::COUNT_W'(HEADER_REPEAT));

    // Decode a completed command run and wrap the counter when it fires
    always_comb
    begin
        res            = '0;
        run_count_next = run;
        last_byte_next = rx_byte;
        if (run_fires && hit.hit)
        begin
            res.mode_valid = 1'b1;
            res.mode_code  = hit.code;
            run_count_next = '0;
        end
        else if (run_fires && (rx_byte == rbcfp_pkg::COARSE_BYTE ||
                               rx_byte == rbcfp_pkg::FINE_BYTE))
        begin
            res.fine_valid = 1'b1;
            res.fine_value = (rx_byte == rbcfp_pkg::FINE_BYTE);
            run_count_next = '0;
        end
    end

    // Update run state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_byte_reg <= '0;
            run_count_reg <= '0;
        end
        else if (advance)
        begin
            last_byte_reg <= last_byte_next;
            run_count_reg <= run_count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rbcfp_frame_track.sv
// Frame tracker: header detection, payload streaming, sum and index gathering, checksum check.
`default_nettype none

module rbcfp_frame_track #(
    parameter int unsigned HEADER_REPEAT = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic [7:0]                        rx_byte,
    input  wire logic [62:0]                       expected_index,
    input  wire logic [rbcfp_pkg::CSUM_LEN_W-1:0]  checksum_length,
    output rbcfp_pkg::frame_res_t                  res
);

    logic [rbcfp_pkg::COUNT_W-1:0]  header_count_reg, header_count_next;
    logic                           in_frame_reg, in_frame_next;
    logic [7:0]                     frame_size_reg, frame_size_next;
    logic [7:0]                     payload_count_reg, payload_count_next;
    logic [2:0]                     sum_count_reg, sum_count_next;
    logic [31:0]                    running_sum_reg, running_sum_next;
    logic [31:0]                    received_sum_reg, received_sum_next;
    logic [63:0]                    index_accum_reg, index_accum_next;
    logic [rbcfp_pkg::CSUM_LEN_W-1:0] eff_len;

    // Clamp the checksum length into its usable range
    always_comb
    begin
        if (checksum_length < rbcfp_pkg::CSUM_LEN_MIN)
        begin
            eff_len = rbcfp_pkg::CSUM_LEN_MIN;
        end
        else if (checksum_length > rbcfp_pkg::CSUM_LEN_MAX)
        begin
            eff_len = rbcfp_pkg::CSUM_LEN_MAX;
        end
        else
        begin
            eff_len = checksum_length;
        end
    end

    // Advance the frame state by one byte
    always_comb
    begin
        res                = '0;
        header_count_next  = header_count_reg;
        in_frame_next      = in_frame_reg;
        frame_size_next    = frame_size_reg;
        payload_count_next = payload_count_reg;
        sum_count_next     = sum_count_reg;
        running_sum_next   = running_sum_reg;
        received_sum_next  = received_sum_reg;
        index_accum_next   = index_accum_reg;

        if (!in_frame_reg)
        begin
            // Open a frame once the header run is complete; this byte is the size
            if (header_count_reg == rbcfp_pkg::COUNT_W'(HEADER_REPEAT))
            begin
                in_frame_next      = 1'b1;
                frame_size_next    = rx_byte;
                payload_count_next = '0;
                sum_count_next     = '0;
                received_sum_next  = '0;
                index_accum_next   = '0;
            end
            if (rx_byte == rbcfp_pkg::FRAME_OPEN_BYTE)
            begin
                if (header_count_reg < rbcfp_pkg::COUNT_MAX)
                begin
                    header_count_next = header_count_reg + 1'b1;
                end
            end
            else
            begin
                header_count_next = '0;
            end
        end
        else if (payload_count_reg < frame_size_reg)
        begin
            // Stream the payload byte, add it to the sum, gather the index
            running_sum_next = running_sum_reg + 32'(rx_byte);
            if (payload_count_reg < rbcfp_pkg::INDEX_BYTES)
            begin
                index_accum_next = index_accum_reg |
                    (64'(rx_byte) << {payload_count_reg[2:0], 3'b000});
            end
            res.payload_valid  = 1'b1;
            res.payload_byte   = rx_byte;
            res.payload_pos    = payload_count_reg;
            payload_count_next = payload_count_reg + 1'b1;
        end
        else
        begin
            // Gather checksum bytes, little-endian
            if (sum_count_reg < 3'd4)
            begin
                received_sum_next = received_sum_reg |
                    (32'(rx_byte) << {sum_count_reg[1:0], 3'b000});
                sum_count_next    = sum_count_reg + 1'b1;
            end
            // Close the frame on the last checksum byte
            if (sum_count_next >= eff_len)
            begin
                res.frame_done = 1'b1;
                if (received_sum_next != running_sum_reg)
                begin
                    res.frame_status = rbcfp_pkg::STATUS_CSUM_MISMATCH;
                end
                else if (index_accum_reg != {1'b0, expected_index})
                begin
                    res.frame_status = rbcfp_pkg::STATUS_INDEX_MISMATCH;
                end
                else
                begin
                    res.frame_status = rbcfp_pkg::STATUS_ACCEPTED;
                end
                res.frame_index    = index_accum_reg[62:0];
                in_frame_next      = 1'b0;
                header_count_next  = '0;
                payload_count_next = '0;
                running_sum_next   = '0;
            end
        end
    end

    // Update frame state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= '0;
            in_frame_reg      <= 1'b0;
            frame_size_reg    <= '0;
            payload_count_reg <= '0;
            sum_count_reg     <= '0;
            running_sum_reg   <= '0;
            received_sum_reg  <= '0;
            index_accum_reg   <= '0;
        end
        else if (advance)
        begin
            header_count_reg  <= header_count_next;
            in_frame_reg      <= in_frame_next;
            frame_size_reg    <= frame_size_next;
            payload_count_reg <= payload_count_next;
            sum_count_reg     <= sum_count_next;
            running_sum_reg   <= running_sum_next;
            received_sum_reg  <= received_sum_next;
            index_accum_reg   <= index_accum_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/repeated_byte_command_and_frame_parser.sv
// Top level of the repeated-byte command and frame parser.
// Takes one received byte per transaction and returns exactly one result per byte from
// the result register, after the byte passes the input register. A byte is accepted every
// cycle while the output is not stalled: the input register feeds the command decoder and
// frame tracker, whose state advances as the byte moves into the result register, so
// throughput is one byte per clock unless stalled. A run of HEADER_REPEAT equal command
// bytes reports a mode or fine/coarse select; HEADER_REPEAT 0xFF bytes open a frame whose
// payload is streamed out, closed with a status after checksum_length (clamped 1..4) bytes.
// Write checksum_length only while no transaction is in flight.
`default_nettype none

module repeated_byte_command_and_frame_parser #(
    parameter int unsigned HEADER_REPEAT = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rbcfp_in_if.sink                               byte_in,
    rbcfp_out_if.source                            result_out,
    input  wire logic                              cfg_we,
    input  wire logic [rbcfp_pkg::CSUM_LEN_W-1:0]  cfg_wdata
);

    logic                                in_valid_reg, in_valid_next;
    rbcfp_pkg::in_item_t                 in_item_reg;
    logic                                out_valid_reg, out_valid_next;
    rbcfp_pkg::out_item_t                out_item_reg, out_item_next;
    logic [rbcfp_pkg::CSUM_LEN_W-1:0]    csum_len_reg;
    logic                                advance;
    logic                                in_ready;
    rbcfp_pkg::cmd_res_t                 cmd_res;
    rbcfp_pkg::frame_res_t               frame_res;

    // Hold the checksum length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csum_len_reg <= rbcfp_pkg::CSUM_LEN_RESET;
        end
        else if (cfg_we)
        begin
            csum_len_reg <= cfg_wdata;
        end
    end

    // Move a byte on when the result register is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign in_ready      = !in_valid_reg || advance;
    assign byte_in.ready = in_ready;

    always_comb
    begin
        in_valid_next = in_ready ? byte_in.valid : in_valid_reg;
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Input and result register valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_ready && byte_in.valid)
        begin
            in_item_reg <= byte_in.payload;
        end
    end

    rbcfp_cmd_decode #(
        .HEADER_REPEAT (HEADER_REPEAT)
    ) u_cmd_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_item_reg.rx_byte),
        .res     (cmd_res)
    );

    rbcfp_frame_track #(
        .HEADER_REPEAT (HEADER_REPEAT)
    ) u_frame_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .rx_byte         (in_item_reg.rx_byte),
        .expected_index  (in_item_reg.expected_index),
        .checksum_length (csum_len_reg),
        .res             (frame_res)
    );

    // Assemble the result transaction
    always_comb
    begin
        out_item_next.mode_valid    = cmd_res.mode_valid;
        out_item_next.mode_code     = cmd_res.mode_code;
        out_item_next.fine_valid    = cmd_res.fine_valid;
        out_item_next.fine_value    = cmd_res.fine_value;
        out_item_next.payload_valid = frame_res.payload_valid;
        out_item_next.payload_byte  = frame_res.payload_byte;
        out_item_next.payload_pos   = frame_res.payload_pos;
        out_item_next.frame_done    = frame_res.frame_done;
        out_item_next.frame_status  = frame_res.frame_status;
        out_item_next.frame_index   = frame_res.frame_index;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_item_reg;

endmodule

`default_nettype wire
